>>> rtl/rct_pkg.sv
// shared types, constants and codes of the reference count table
package rct_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int ADDR_W      = 32;
    localparam int COUNT_W     = 16;

    localparam logic REQ_REGISTER = 1'b0;
    localparam logic REQ_ASSIGN   = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_SATURATED = 2'd3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic              req_type;
        logic              old_valid;
        logic [ADDR_W-1:0] old_address;
        logic              new_valid;
        logic [ADDR_W-1:0] new_address;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               freed_valid;
        logic [ADDR_W-1:0]  freed_address;
        logic [COUNT_W-1:0] new_count;
    } out_word_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_FIRST,
        CS_NEW,
        CS_DONE
    } ctrl_state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_REGISTER,
        OP_DROP,
        OP_ADD,
        OP_SAME
    } dp_op_t;

    typedef struct packed {
        logic   capture;
        dp_op_t op;
        logic   key_new;
        logic   publish;
    } dp_cmd_t;

    typedef struct packed {
        logic req_type;
        logic old_valid;
        logic new_valid;
        logic hit;
        logic same_addr;
        logic out_busy;
    } dp_stat_t;

endpackage

>>> rtl/reference_count_table.sv
// reference count table: tracked addresses with counts, register and assign requests
// each word is captured, then looked up once for a register or one-sided assign, and once
// per side when an assign touches both old and new entries; at most one table lookup per cycle
// the sequencer steps the shared lookup, taking a new word only after the last is published
// the output register lets the next word be taken while a result waits to be read
// reset (synchronous, aresetn low): table empty, sequencer idle, no result pending
module reference_count_table #(
    parameter int ENTRIES = rct_pkg::ENTRIES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rct_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output rct_pkg::out_word_t m_data
);
    import rct_pkg::*;

    // command and status between sequencer and datapath
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: idle, first lookup (register, old side or lone new side),
    // new side of a two-sided assign, then hand-off once the output is free
    rct_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath: valid bits, address and count storage, parallel match,
    // result accumulation and the output register
    rct_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule

>>> rtl/rct_datapath.sv
// table storage, parallel address match, count update and result registers
module rct_datapath #(
    parameter int ENTRIES = rct_pkg::ENTRIES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  rct_pkg::in_word_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rct_pkg::out_word_t m_data,
    input  rct_pkg::dp_cmd_t  cmd,
    output rct_pkg::dp_stat_t stat
);
    import rct_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);

    in_word_t           req_reg;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [ADDR_W-1:0]  addr_mem [ENTRIES];
    logic [COUNT_W-1:0] cnt_mem  [ENTRIES];

    logic [1:0]         status_reg, status_next;
    logic               freed_reg, freed_next;
    logic [ADDR_W-1:0]  freed_addr_reg, freed_addr_next;
    logic [COUNT_W-1:0] ncount_reg, ncount_next;

    out_word_t          out_reg;
    logic               m_valid_reg, m_valid_next;

    logic [ADDR_W-1:0]  key;
    logic [ENTRIES-1:0] hit_vec;
    logic               hit, full;
    logic [IDX_W-1:0]   hit_idx, free_idx, sel_idx;
    logic [COUNT_W-1:0] hit_cnt, cnt_dec;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [COUNT_W-1:0] wr_cnt;

    // match over all valid entries, lowest index wins
    always_comb begin
        key      = cmd.key_new ? req_reg.new_address : req_reg.old_address;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            hit_vec[i] = valid_reg[i] && (addr_mem[i] == key);
            if (hit_vec[i]) begin
                hit_idx = IDX_W'(i);
            end
            if (!valid_reg[i]) begin
                free_idx = IDX_W'(i);
            end
        end
        hit     = |hit_vec;
        full    = &valid_reg;
        hit_cnt = cnt_mem[hit_idx];
        cnt_dec = (hit_cnt == '0) ? '0 : hit_cnt - COUNT_W'(1);
    end

    always_comb begin
        valid_next      = valid_reg;
        status_next     = status_reg;
        freed_next      = freed_reg;
        freed_addr_next = freed_addr_reg;
        ncount_next     = ncount_reg;
        wr_en           = 1'b0;
        sel_idx         = hit_idx;
        wr_addr         = addr_mem[hit_idx];
        wr_cnt          = hit_cnt;

        if (cmd.capture) begin
            status_next     = ST_OK;
            freed_next      = 1'b0;
            freed_addr_next = '0;
            ncount_next     = '0;
        end

        unique case (cmd.op)
            OP_REGISTER: begin
                if (!hit && full) begin
                    status_next = ST_FULL;
                end else begin
                    sel_idx             = hit ? hit_idx : free_idx;
                    wr_en               = 1'b1;
                    wr_addr             = req_reg.new_address;
                    wr_cnt              = COUNT_W'(1);
                    valid_next[sel_idx] = 1'b1;
                    ncount_next         = COUNT_W'(1);
                end
            end
            OP_DROP: begin
                if (!hit) begin
                    status_next = ST_NOT_FOUND;
                end else begin
                    wr_en  = 1'b1;
                    wr_cnt = cnt_dec;
                    if (cnt_dec == '0) begin
                        valid_next[hit_idx] = 1'b0;
                        freed_next          = 1'b1;
                        freed_addr_next     = addr_mem[hit_idx];
                    end
                end
            end
            OP_ADD: begin
                if (!hit) begin
                    status_next = ST_NOT_FOUND;
                    ncount_next = '0;
                end else if (hit_cnt == COUNT_MAX) begin
                    ncount_next = COUNT_MAX;
                    if (status_reg == ST_OK) begin
                        status_next = ST_SATURATED;
                    end
                end else begin
                    wr_en       = 1'b1;
                    wr_cnt      = hit_cnt + COUNT_W'(1);
                    ncount_next = hit_cnt + COUNT_W'(1);
                end
            end
            OP_SAME: begin
                ncount_next = hit_cnt;
            end
            default: begin
            end
        endcase

        if (cmd.publish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            addr_mem[sel_idx] <= wr_addr;
            cnt_mem[sel_idx]  <= wr_cnt;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= s_data;
        end
        status_reg     <= status_next;
        freed_reg      <= freed_next;
        freed_addr_reg <= freed_addr_next;
        ncount_reg     <= ncount_next;
        if (cmd.publish) begin
            out_reg.status        <= status_reg;
            out_reg.freed_valid   <= freed_reg;
            out_reg.freed_address <= freed_addr_reg;
            out_reg.new_count     <= ncount_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign stat.req_type  = req_reg.req_type;
    assign stat.old_valid = req_reg.old_valid;
    assign stat.new_valid = req_reg.new_valid;
    assign stat.hit       = hit;
    assign stat.same_addr = (req_reg.old_address == req_reg.new_address);
    assign stat.out_busy  = m_valid_reg && !m_ready;

endmodule

>>> rtl/rct_ctrl.sv
// request sequencer: register or old side, new side, then hand-off to the output register
module rct_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rct_pkg::dp_stat_t stat,
    output rct_pkg::dp_cmd_t  cmd
);
    import rct_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        cmd.capture = 1'b0;
        cmd.op      = OP_NONE;
        cmd.key_new = 1'b0;
        cmd.publish = 1'b0;

        unique case (state_reg)
            CS_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = CS_FIRST;
                end
            end
            CS_FIRST: begin
                priority if (stat.req_type == REQ_REGISTER) begin
                    cmd.op      = OP_REGISTER;
                    cmd.key_new = 1'b1;
                    state_next  = CS_DONE;
                end else if (stat.old_valid) begin
                    // lookup keyed by the old address
                    if (stat.hit && stat.new_valid && stat.same_addr) begin
                        cmd.op     = OP_SAME;
                        state_next = CS_DONE;
                    end else begin
                        cmd.op     = OP_DROP;
                        state_next = stat.new_valid ? CS_NEW : CS_DONE;
                    end
                end else if (stat.new_valid) begin
                    cmd.op      = OP_ADD;
                    cmd.key_new = 1'b1;
                    state_next  = CS_DONE;
                end else begin
                    state_next = CS_DONE;
                end
            end
            CS_NEW: begin
                cmd.op      = OP_ADD;
                cmd.key_new = 1'b1;
                state_next  = CS_DONE;
            end
            CS_DONE: begin
                if (!stat.out_busy) begin
                    cmd.publish = 1'b1;
                    state_next  = CS_IDLE;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench of the reference count table with a shadow table predictor
module testbench;
    import rct_pkg::*;

    localparam int TABLE_DEPTH  = ENTRIES_DEF;
    localparam int POOL_SIZE    = 24;
    localparam int RANDOM_WORDS = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 12;

    // one row of the opening script: request word, and its result where it is typed in
    typedef struct packed {
        in_word_t  word;
        logic      has_result;
        out_word_t result;
    } stim_row_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    // shadow copy of the tracked table
    logic               tbl_valid [TABLE_DEPTH];
    logic [ADDR_W-1:0]  tbl_addr  [TABLE_DEPTH];
    logic [COUNT_W-1:0] tbl_count [TABLE_DEPTH];

    out_word_t pending_results [$];
    stim_row_t directed_requests [$];
    out_word_t expected_word;
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

    // calm: both sides stop idling for a stretch
    bit calm         = 1'b0;
    bit hold_pending = 1'b0;
    int mismatches   = 0;
    int quiet_cycles = 0;

    reference_count_table #(
        .ENTRIES(TABLE_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #1 aclk = ~aclk;

    // search over the valid entries, lowest index first, -1 on a miss
    function automatic int find_tracked(logic [ADDR_W-1:0] addr);
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (tbl_valid[i] && tbl_addr[i] == addr)
                return i;
        return -1;
    endfunction

    // applies one request word to the shadow table and returns its result word
    function automatic out_word_t apply_request(in_word_t w);
        out_word_t r;
        int        slot;
        int        old_slot;
        r = '0;
        r.status = ST_OK;
        if (w.req_type == REQ_REGISTER) begin
            // tracked address is reset to one, else the lowest free slot is taken
            slot = find_tracked(w.new_address);
            if (slot < 0)
                for (int i = 0; i < TABLE_DEPTH; i++)
                    if (!tbl_valid[i] && slot < 0)
                        slot = i;
            if (slot < 0) begin
                r.status = ST_FULL;
            end else begin
                tbl_valid[slot] = 1'b1;
                tbl_addr[slot]  = w.new_address;
                tbl_count[slot] = COUNT_W'(1);
                r.new_count     = COUNT_W'(1);
            end
        end else begin
            old_slot = w.old_valid ? find_tracked(w.old_address) : -1;
            if (w.old_valid && w.new_valid && old_slot >= 0 && w.old_address == w.new_address) begin
                // self assignment leaves the count alone
                r.new_count = tbl_count[old_slot];
            end else begin
                if (w.old_valid) begin
                    if (old_slot < 0) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        if (tbl_count[old_slot] != 0)
                            tbl_count[old_slot] = tbl_count[old_slot] - COUNT_W'(1);
                        if (tbl_count[old_slot] == 0) begin
                            tbl_valid[old_slot] = 1'b0;
                            r.freed_valid       = 1'b1;
                            r.freed_address     = tbl_addr[old_slot];
                        end
                    end
                end
                if (w.new_valid) begin
                    slot = find_tracked(w.new_address);
                    if (slot < 0) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        // saturation drops the increment, not found keeps precedence
                        if (tbl_count[slot] == COUNT_MAX) begin
                            if (r.status == ST_OK)
                                r.status = ST_SATURATED;
                        end else begin
                            tbl_count[slot] = tbl_count[slot] + COUNT_W'(1);
                        end
                        r.new_count = tbl_count[slot];
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic in_word_t req_word(logic rt, logic ov, logic [ADDR_W-1:0] oa,
                                          logic nv, logic [ADDR_W-1:0] na);
        in_word_t w;
        w.req_type    = rt;
        w.old_valid   = ov;
        w.old_address = oa;
        w.new_valid   = nv;
        w.new_address = na;
        return w;
    endfunction

    function automatic out_word_t result_word(logic [1:0] st, logic fv, logic [ADDR_W-1:0] fa,
                                              logic [COUNT_W-1:0] cnt);
        out_word_t r;
        r.status        = st;
        r.freed_valid   = fv;
        r.freed_address = fa;
        r.new_count     = cnt;
        return r;
    endfunction

    function automatic void add_row(in_word_t w, logic has_result, out_word_t r);
        directed_requests.push_back({w, has_result, r});
    endfunction

    task automatic check_field(string field, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    // offers one word, called and returning at a falling edge
    task automatic send_request(in_word_t w, logic has_result, out_word_t typed_result);
        int        gap;
        out_word_t predicted;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        // the shadow table always follows, typed rows only replace the compared value
        predicted = apply_request(w);
        pending_results.push_back(has_result ? typed_result : predicted);
        @(negedge aclk);
    endtask

    // result side: random stalls, one long hold-off when asked
    initial begin
        int stall;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (hold_pending) begin
                stall        = HOLD_CYCLES;
                hold_pending = 1'b0;
            end else begin
                stall = calm ? 0 : $urandom_range(0, 5);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // result check against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: unexpected result word, expected none, got %p", $time, m_data);
                mismatches++;
            end else begin
                expected_word = pending_results.pop_front();
                check_field("status", expected_word.status, m_data.status);
                check_field("freed_valid", expected_word.freed_valid, m_data.freed_valid);
                check_field("freed_address", expected_word.freed_address, m_data.freed_address);
                check_field("new_count", expected_word.new_count, m_data.new_count);
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("reference_count_table test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int                k;
        int                pick;
        in_word_t          w;
        logic [ADDR_W-1:0] sat_addr;
        sat_addr = '1;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_addr[i]  = '0;
            tbl_count[i] = '0;
        end
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // opening script on an empty table
        // both sides unknown
        add_row(req_word(REQ_ASSIGN, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000), 1'b1,
                result_word(ST_NOT_FOUND, 1'b0, '0, '0));
        // both sides null
        add_row(req_word(REQ_ASSIGN, 1'b0, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF), 1'b1,
                result_word(ST_OK, 1'b0, '0, '0));
        // register ignores the old side and new_valid
        add_row(req_word(REQ_REGISTER, 1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000), 1'b1,
                result_word(ST_OK, 1'b0, '0, COUNT_W'(1)));
        add_row(req_word(REQ_REGISTER, 1'b0, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF), 1'b1,
                result_word(ST_OK, 1'b0, '0, COUNT_W'(1)));
        // null receiver still takes the reference
        add_row(req_word(REQ_ASSIGN, 1'b0, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF), 1'b1,
                result_word(ST_OK, 1'b0, '0, COUNT_W'(2)));
        // register of a tracked address sets it back to one
        add_row(req_word(REQ_REGISTER, 1'b0, 32'h0000_0000, 1'b0, 32'hFFFF_FFFF), 1'b1,
                result_word(ST_OK, 1'b0, '0, COUNT_W'(1)));
        add_row(req_word(REQ_ASSIGN, 1'b0, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF), 1'b0, '0);
        // old side drops to zero and is released
        add_row(req_word(REQ_ASSIGN, 1'b1, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF), 1'b1,
                result_word(ST_OK, 1'b1, 32'h0000_0000, COUNT_W'(3)));
        // old equals new
        add_row(req_word(REQ_ASSIGN, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF), 1'b0, '0);
        // unknown old, new side still counted
        add_row(req_word(REQ_ASSIGN, 1'b1, 32'h1234_5678, 1'b1, 32'hFFFF_FFFF), 1'b0, '0);
        // unknown new, old side still dropped
        add_row(req_word(REQ_ASSIGN, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'hEDCB_A987), 1'b0, '0);
        // lowest free slot is reused
        add_row(req_word(REQ_REGISTER, 1'b0, 32'h0000_0000, 1'b1, 32'h0000_0000), 1'b0, '0);
        for (int i = 0; i < TABLE_DEPTH - 2; i++)
            add_row(req_word(REQ_REGISTER, 1'b0, '0, 1'b0, 32'hA5A5_0000 | i), 1'b0, '0);
        // table full
        add_row(req_word(REQ_REGISTER, 1'b0, '0, 1'b1, 32'h5A5A_5A5A), 1'b1,
                result_word(ST_FULL, 1'b0, '0, '0));
        // tracked address still registers on a full table
        add_row(req_word(REQ_REGISTER, 1'b0, '0, 1'b0, 32'h0000_0000), 1'b1,
                result_word(ST_OK, 1'b0, '0, COUNT_W'(1)));
        add_row(req_word(REQ_ASSIGN, 1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000), 1'b0, '0);

        foreach (directed_requests[i])
            send_request(directed_requests[i].word, directed_requests[i].has_result,
                         directed_requests[i].result);

        // unknown old with a tracked new side, then a self assignment
        send_request(req_word(REQ_ASSIGN, 1'b1, 32'h1234_5678, 1'b1, sat_addr), 1'b0, '0);
        send_request(req_word(REQ_ASSIGN, 1'b1, sat_addr, 1'b1, sat_addr), 1'b0, '0);
        send_request(req_word(REQ_ASSIGN, 1'b1, 32'hA5A5_0000, 1'b1, sat_addr), 1'b0, '0);
        send_request(req_word(REQ_REGISTER, 1'b0, '0, 1'b0, sat_addr), 1'b1,
                     result_word(ST_OK, 1'b0, '0, COUNT_W'(1)));
        send_request(req_word(REQ_ASSIGN, 1'b1, sat_addr, 1'b0, '0), 1'b1,
                     result_word(ST_OK, 1'b1, sat_addr, '0));

        // random part: addresses mostly from a pool seeded with what is tracked
        for (k = 0; k < POOL_SIZE; k++)
            addr_pool[k] = (k < TABLE_DEPTH && tbl_valid[k]) ? tbl_addr[k] : $urandom();
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_WORDS / 3)
                hold_pending = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                // noise: any field value at all
                w.req_type    = 1'($urandom_range(0, 1));
                w.old_valid   = 1'($urandom_range(0, 1));
                w.old_address = $urandom();
                w.new_valid   = 1'($urandom_range(0, 1));
                w.new_address = $urandom();
            end else begin
                w.req_type    = ($urandom_range(0, 3) == 0) ? REQ_REGISTER : REQ_ASSIGN;
                w.old_valid   = ($urandom_range(0, 9) != 0);
                w.old_address = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
                w.new_valid   = ($urandom_range(0, 9) != 0);
                w.new_address = ($urandom_range(0, 9) == 0) ?
                                w.old_address : addr_pool[$urandom_range(0, POOL_SIZE - 1)];
            end
            send_request(w, 1'b0, '0);
            // now and then swap an untracked pool address for a fresh one
            if ($urandom_range(0, 31) == 0) begin
                k = $urandom_range(0, POOL_SIZE - 1);
                if (find_tracked(addr_pool[k]) < 0)
                    addr_pool[k] = $urandom();
            end
        end

        s_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("reference_count_table test passed");
        else
            $display("reference_count_table test failed");
        $finish;
    end

endmodule
